@@ design/rmf_pkg.sv @@
// Package with the shared types and constants of the RGB 3x3 median filter.
package rmf_pkg;

  // Width of the frame dimension registers.
  localparam int CfgW = 11;

  // Configuration register indexes.
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  // Request type codes.
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef logic [7:0] chan_t;

  // Packed pixel as held in the line buffers and the window.
  typedef struct packed {
    logic  sel;
    chan_t blue;
    chan_t green;
    chan_t red;
  } pix_t;

  // Which window edges fall outside the frame.
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } border_t;

endpackage

@@ design/rmf_line_buffer.sv @@
// Two line buffers holding the original pixels of the two previous rows.
module rmf_line_buffer import rmf_pkg::*; #(
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  input  pix_t                     new_pix_i,
  input  logic                     wr_up_en_i,
  input  logic [$clog2(Depth)-1:0] wr_up_addr_i,
  output pix_t                     up_o,
  output pix_t                     mid_o
);

  pix_t upper_mem  [Depth];
  pix_t middle_mem [Depth];
  pix_t up_q;
  pix_t mid_q;

  // Middle line: read the old entry and store the new pixel in the same cycle.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      mid_q <= middle_mem[rd_addr_i];
      middle_mem[rd_addr_i] <= new_pix_i;
    end
  end

  // Upper line: read at acceptance, later take the old middle entry.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      up_q <= upper_mem[rd_addr_i];
    end
    if (wr_up_en_i) begin
      upper_mem[wr_up_addr_i] <= mid_q;
    end
  end

  assign up_o  = up_q;
  assign mid_o = mid_q;

endmodule

@@ design/rmf_median.sv @@
// Rank-based median of up to nine 8-bit values, result in half units.
module rmf_median import rmf_pkg::*; (
  input  chan_t      vals_i [9],
  input  logic [8:0] mask_i,
  output logic [8:0] med_o
);

  logic [3:0] rank [9];
  logic [3:0] cnt;
  logic [3:0] half;
  chan_t      hi_val;
  chan_t      lo_val;

  // Each selected value gets its rank among the selected values; ties break by index.
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      rank[i] = '0;
      for (int j = 0; j < 9; j++) begin
        if (j != i && mask_i[j] &&
            ((vals_i[j] < vals_i[i]) || (vals_i[j] == vals_i[i] && j < i))) begin
          rank[i] = rank[i] + 4'd1;
        end
      end
    end
  end

  assign cnt  = 4'($countones(mask_i));
  assign half = cnt >> 1;

  // Pick the one or two middle values.
  always_comb begin
    hi_val = '0;
    lo_val = '0;
    for (int i = 0; i < 9; i++) begin
      if (mask_i[i] && rank[i] == half) begin
        hi_val = hi_val | vals_i[i];
      end
      if (mask_i[i] && rank[i] == half - 4'd1) begin
        lo_val = lo_val | vals_i[i];
      end
    end
  end

  assign med_o = cnt[0] ? {hi_val, 1'b0} : ({1'b0, hi_val} + {1'b0, lo_val});

endmodule

@@ design/rgb_median_3x3_filter_core.sv @@
// Top level of the streaming RGB 3x3 median filter.
// Pixels arrive in raster order and the block accepts one item per clock while
// no result waits in the output register. Each item passes through a line-buffer
// read stage and a window stage, and the median network sits between the window
// and the output register, so a result is registered after the window stage.
// The sustained rate is one item per cycle while the output is taken, and the whole
// pipeline stalls only while a result waits in the output register.
// The result for a pixel appears when the item one line plus one pixel later is
// accepted; after the last pixel of a frame, frame_width + 1 drain items flush
// the remaining results. Every result is in half units (value times two); a
// pixel whose select bit is clear passes through unchanged. A window clipped at
// the frame border holds four or six pixels and gives the mean of the two middle
// values. The line buffers need no clearing after reset.
module rgb_median_3x3_filter_core import rmf_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            req_type_i,
  input  logic [7:0]      in_red_i,
  input  logic [7:0]      in_green_i,
  input  logic [7:0]      in_blue_i,
  input  logic            apply_filter_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [8:0]      out_red_o,
  output logic [8:0]      out_green_o,
  output logic [8:0]      out_blue_o,
  output logic            frame_last_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int MW = (WW > RW) ? WW : RW;
  localparam int PW = ((MW > CfgW) ? MW : CfgW) + 1;

  logic [CfgW-1:0] cfg_width_q;
  logic [CfgW-1:0] cfg_height_q;
  logic [CW-1:0]   col_q;
  logic [RW-1:0]   row_q;

  logic            advance;
  logic            in_fire;

  logic [PW-1:0]   w;
  logic [PW-1:0]   h;
  logic [PW-1:0]   cc;
  logic [PW-1:0]   rr;
  logic [PW-1:0]   r;
  logic [PW-1:0]   c;
  logic [PW-1:0]   nc;
  logic [PW-1:0]   nr;
  logic            emit;
  logic            last;
  border_t         border;
  pix_t            new_pix;

  logic            s1_valid_q;
  logic            s1_emit_q;
  logic            s1_last_q;
  border_t         s1_border_q;
  logic [CW-1:0]   s1_addr_q;
  pix_t            s1_pix_q;
  pix_t            up_pix;
  pix_t            mid_pix;

  logic            s2_valid_q;
  logic            s2_last_q;
  border_t         s2_border_q;
  pix_t            win_q [9];

  logic [8:0]      mask;
  chan_t           red_vals   [9];
  chan_t           green_vals [9];
  chan_t           blue_vals  [9];
  logic [8:0]      red_med;
  logic [8:0]      green_med;
  logic [8:0]      blue_med;

  logic            out_valid_q;
  logic [8:0]      out_red_q;
  logic [8:0]      out_green_q;
  logic [8:0]      out_blue_q;
  logic            out_last_q;

  // The whole pipeline moves unless a result waits in the output register.
  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = advance;
  assign in_fire     = in_valid_i && advance;
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= CfgW'(1024);
      cfg_height_q <= CfgW'(1024);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_FRAME_WIDTH) begin
        cfg_width_q <= cfg_data_i;
      end else begin
        cfg_height_q <= cfg_data_i;
      end
    end
  end

  // Frame dimensions clamped to the supported range.
  always_comb begin
    w = PW'(cfg_width_q);
    if (w < PW'(2)) begin
      w = PW'(2);
    end else if (w > PW'(MAX_WIDTH)) begin
      w = PW'(MAX_WIDTH);
    end
    h = PW'(cfg_height_q);
    if (h < PW'(2)) begin
      h = PW'(2);
    end else if (h > PW'(MAX_HEIGHT)) begin
      h = PW'(MAX_HEIGHT);
    end
  end

  // Position of the incoming item, the pixel whose result it releases, and the next position.
  always_comb begin
    cc = PW'(col_q);
    rr = PW'(row_q);
    if (cc >= w) begin
      cc = '0;
      rr = rr + PW'(1);
    end
    if (rr > h + PW'(1) || (rr == h + PW'(1) && cc != '0)) begin
      rr = '0;
      cc = '0;
    end
    emit = (rr >= PW'(2)) || (rr == PW'(1) && cc >= PW'(1));
    if (cc >= PW'(1)) begin
      r = rr - PW'(1);
      c = cc - PW'(1);
    end else begin
      r = rr - PW'(2);
      c = w - PW'(1);
    end
    nc = cc + PW'(1);
    nr = rr;
    if (nc >= w) begin
      nc = '0;
      nr = rr + PW'(1);
    end
    last = emit && (r == h - PW'(1)) && (c == w - PW'(1));
    if (last) begin
      nc = '0;
      nr = '0;
    end
    border.top    = (r == '0);
    border.bottom = (r >= h - PW'(1));
    border.left   = (c == '0);
    border.right  = (c >= w - PW'(1));
  end

  // A drain item enters as a black, unselected pixel.
  always_comb begin
    new_pix = '0;
    if (req_type_i == REQ_PIXEL) begin
      new_pix.red   = in_red_i;
      new_pix.green = in_green_i;
      new_pix.blue  = in_blue_i;
      new_pix.sel   = apply_filter_i;
    end
  end

  // Position counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= CW'(nc);
      row_q <= RW'(nr);
    end
  end

  rmf_line_buffer #(
    .Depth (MAX_WIDTH)
  ) u_line_buffer (
    .clk_i        (clk_i),
    .rd_en_i      (in_fire),
    .rd_addr_i    (CW'(cc)),
    .new_pix_i    (new_pix),
    .wr_up_en_i   (advance && s1_valid_q),
    .wr_up_addr_i (s1_addr_q),
    .up_o         (up_pix),
    .mid_o        (mid_pix)
  );

  // Stage one: item data while the line buffers are read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_emit_q   <= emit;
      s1_last_q   <= last;
      s1_border_q <= border;
      s1_addr_q   <= CW'(cc);
      s1_pix_q    <= new_pix;
    end
  end

  // Stage two: the window shifts in the new column.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (advance) begin
      s2_valid_q <= s1_valid_q && s1_emit_q;
      if (s1_valid_q) begin
        for (int k = 0; k < 3; k++) begin
          win_q[k*3]   <= win_q[k*3+1];
          win_q[k*3+1] <= win_q[k*3+2];
        end
        win_q[2] <= up_pix;
        win_q[5] <= mid_pix;
        win_q[8] <= s1_pix_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      s2_last_q   <= s1_last_q;
      s2_border_q <= s1_border_q;
    end
  end

  // Window entries that lie inside the frame.
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      mask[k] = !((k / 3 == 0 && s2_border_q.top) || (k / 3 == 2 && s2_border_q.bottom) ||
                  (k % 3 == 0 && s2_border_q.left) || (k % 3 == 2 && s2_border_q.right));
      red_vals[k]   = win_q[k].red;
      green_vals[k] = win_q[k].green;
      blue_vals[k]  = win_q[k].blue;
    end
  end

  rmf_median u_median_red (
    .vals_i (red_vals),
    .mask_i (mask),
    .med_o  (red_med)
  );

  rmf_median u_median_green (
    .vals_i (green_vals),
    .mask_i (mask),
    .med_o  (green_med)
  );

  rmf_median u_median_blue (
    .vals_i (blue_vals),
    .mask_i (mask),
    .med_o  (blue_med)
  );

  // Output register: filtered or passed-through center pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s2_valid_q) begin
      out_last_q <= s2_last_q;
      if (win_q[4].sel) begin
        out_red_q   <= red_med;
        out_green_q <= green_med;
        out_blue_q  <= blue_med;
      end else begin
        out_red_q   <= {win_q[4].red, 1'b0};
        out_green_q <= {win_q[4].green, 1'b0};
        out_blue_q  <= {win_q[4].blue, 1'b0};
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_red_o    = out_red_q;
  assign out_green_o  = out_green_q;
  assign out_blue_o   = out_blue_q;
  assign frame_last_o = out_last_q;

endmodule
